@@ rtl/mlqws_pkg.sv @@
// Shared types and constants for the multilevel weighted slot scheduler.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package mlqws_pkg;

  localparam int TagW = 16;
  localparam int LvlW = 3;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DROP  = 2'd1,
    ST_GRANT = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TAG
  } state_e;

  // Classified command as it leaves the front queue.
  typedef struct packed {
    op_e             opcode;
    logic [TagW-1:0] tag;
    logic [LvlW-1:0] level;
    logic            drop;
  } cmd_t;

  typedef struct packed {
    status_e         status;
    logic [TagW-1:0] tag;
    logic [LvlW-1:0] level;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/mlqws_front.sv @@
// Front end: two-entry command queue that accepts beats and flags enqueues
// to levels that do not exist. Depends on mlqws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlqws_front import mlqws_pkg::*; #(
  parameter int NUM_LEVELS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic      full,
  input  wire op_e  opcode_i,
  input  wire logic [TagW-1:0] task_tag_i,
  input  wire logic [LvlW-1:0] level_i,
  output logic      cmd_valid_o,
  output cmd_t      cmd_o,
  input  wire logic cmd_pop_i
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;
  cmd_t       cmd_in;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_in.opcode = opcode_i;
    cmd_in.tag    = task_tag_i;
    cmd_in.level  = level_i;
    cmd_in.drop   = (opcode_i == OP_ENQ) && (int'(level_i) >= NUM_LEVELS);
  end

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mlqws_back.sv @@
// Back end: level descriptors, credit memory, tag memory and the sequencer
// that serves one command at a time. Depends on mlqws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlqws_back import mlqws_pkg::*; #(
  parameter int NUM_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  wire logic res_ready_i,
  output logic      res_push_o,
  output res_t      res_o
);

  localparam int LW   = $clog2(NUM_LEVELS);
  localparam int HW   = $clog2(LEVEL_DEPTH);
  localparam int CNTW = $clog2(LEVEL_DEPTH + 1);
  localparam int DW   = HW + CNTW;
  localparam int CW   = $clog2(NUM_LEVELS + 1);
  localparam int AW   = $clog2(NUM_LEVELS * LEVEL_DEPTH);
  localparam int SW   = (TAG_BITS < TagW) ? TAG_BITS : TagW;

  logic [SW-1:0] tag_mem  [NUM_LEVELS*LEVEL_DEPTH];
  logic [DW-1:0] desc_mem [NUM_LEVELS];
  logic [CW-1:0] cred_mem [NUM_LEVELS];

  state_e state_q, state_d;

  logic [NUM_LEVELS-1:0] nonempty_q, nonempty_d;
  logic [NUM_LEVELS-1:0] cred_ok_q, cred_ok_d;
  logic [NUM_LEVELS-1:0] fresh_q, fresh_d;
  logic [NUM_LEVELS-1:0] desc_vld_q, desc_vld_d;

  logic [LW-1:0]   sel_q;
  logic            is_enq_q;
  logic [SW-1:0]   tag_q;
  logic [DW-1:0]   desc_rd_q;
  logic [CW-1:0]   cred_rd_q;
  logic [SW-1:0]   tag_rd_q;

  logic [NUM_LEVELS-1:0] ready_v;
  logic [LW-1:0]   enc_ready, enc_ne, pick;
  logic            any_ready, any_ne, cmd_go, is_enq, refill, instant;

  logic [DW-1:0]   desc_cur;
  logic [HW-1:0]   head, head_nx, pos;
  logic [CNTW-1:0] cnt, cnt_m1;
  logic [CNTW:0]   pos_sum;
  logic [CW-1:0]   cred, cred_m1;
  logic            lvl_full;
  logic [AW-1:0]   base, tag_addr;

  logic            tag_we, tag_re, desc_we, cred_we;
  logic [DW-1:0]   desc_wd;

  // Priority encoders over the per-level flags, lowest index wins.
  assign ready_v = nonempty_q & cred_ok_q;

  always_comb begin
    enc_ready = '0;
    enc_ne    = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (ready_v[i]) begin
        enc_ready = LW'(i);
      end
      if (nonempty_q[i]) begin
        enc_ne = LW'(i);
      end
    end
  end

  assign any_ready = |ready_v;
  assign any_ne    = |nonempty_q;
  assign is_enq    = (cmd_i.opcode == OP_ENQ);
  assign cmd_go    = (state_q == S_IDLE) && cmd_valid_i && res_ready_i;
  assign refill    = !is_enq && !any_ready;
  assign instant   = is_enq ? cmd_i.drop : !any_ne;
  assign pick      = is_enq ? LW'(cmd_i.level) : (any_ready ? enc_ready : enc_ne);

  // Current descriptor and credit of the selected level.
  always_comb begin
    desc_cur = desc_vld_q[sel_q] ? desc_rd_q : '0;
    head     = desc_cur[DW-1:CNTW];
    cnt      = desc_cur[CNTW-1:0];
    cred     = fresh_q[sel_q] ? (CW'(NUM_LEVELS) - CW'(sel_q)) : cred_rd_q;
    cred_m1  = cred - CW'(1);
    cnt_m1   = cnt - CNTW'(1);
    lvl_full = (cnt == CNTW'(LEVEL_DEPTH));
    pos_sum  = (CNTW + 1)'(head) + (CNTW + 1)'(cnt);
    pos      = (pos_sum >= (CNTW + 1)'(LEVEL_DEPTH)) ?
               HW'(pos_sum - (CNTW + 1)'(LEVEL_DEPTH)) : HW'(pos_sum);
    head_nx  = (head == HW'(LEVEL_DEPTH - 1)) ? '0 : head + HW'(1);
    base     = AW'(sel_q) * AW'(LEVEL_DEPTH);
    tag_addr = base + (is_enq_q ? AW'(pos) : AW'(head));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_go && !instant) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = is_enq_q ? S_IDLE : S_TAG;
      end
      S_TAG: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs and flag updates.
  always_comb begin
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '{status: ST_ENQ, tag: '0, level: '0};
    tag_we      = 1'b0;
    tag_re      = 1'b0;
    desc_we     = 1'b0;
    cred_we     = 1'b0;
    desc_wd     = '0;
    nonempty_d  = nonempty_q;
    cred_ok_d   = cred_ok_q;
    fresh_d     = fresh_q;
    desc_vld_d  = desc_vld_q;
    case (state_q)
      S_IDLE: begin
        cmd_pop_o = cmd_go;
        if (cmd_go) begin
          if (refill) begin
            cred_ok_d = '1;
            fresh_d   = '1;
          end
          if (instant) begin
            res_push_o   = 1'b1;
            res_o.status = is_enq ? ST_DROP : ST_NONE;
          end
        end
      end
      S_EXEC: begin
        if (is_enq_q) begin
          res_push_o = 1'b1;
          if (lvl_full) begin
            res_o.status = ST_DROP;
          end else begin
            res_o.status       = ST_ENQ;
            tag_we             = 1'b1;
            desc_we            = 1'b1;
            desc_wd            = {head, cnt + CNTW'(1)};
            nonempty_d[sel_q]  = 1'b1;
            desc_vld_d[sel_q]  = 1'b1;
          end
        end else begin
          tag_re            = 1'b1;
          desc_we           = 1'b1;
          cred_we           = 1'b1;
          desc_wd           = {head_nx, cnt_m1};
          nonempty_d[sel_q] = (cnt_m1 != '0);
          cred_ok_d[sel_q]  = (cred_m1 != '0);
          fresh_d[sel_q]    = 1'b0;
          desc_vld_d[sel_q] = 1'b1;
        end
      end
      S_TAG: begin
        res_push_o   = 1'b1;
        res_o.status = ST_GRANT;
        res_o.tag    = TagW'(tag_rd_q);
        res_o.level  = LvlW'(sel_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      nonempty_q <= '0;
      cred_ok_q  <= '1;
      fresh_q    <= '1;
      desc_vld_q <= '0;
    end else begin
      state_q    <= state_d;
      nonempty_q <= nonempty_d;
      cred_ok_q  <= cred_ok_d;
      fresh_q    <= fresh_d;
      desc_vld_q <= desc_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_go) begin
      sel_q     <= pick;
      is_enq_q  <= is_enq;
      tag_q     <= SW'(cmd_i.tag);
      desc_rd_q <= desc_mem[pick];
      cred_rd_q <= cred_mem[pick];
    end
    if (desc_we) begin
      desc_mem[sel_q] <= desc_wd;
    end
    if (cred_we) begin
      cred_mem[sel_q] <= cred_m1;
    end
    if (tag_we) begin
      tag_mem[tag_addr] <= tag_q;
    end
    if (tag_re) begin
      tag_rd_q <= tag_mem[tag_addr];
    end
  end

  a_tag_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TAG |-> $past(state_q) == S_EXEC)
    else $error("tag stage entered without an execute stage");

  a_deq_level_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC && !is_enq_q |-> nonempty_q[sel_q] && cred_ok_q[sel_q] && cnt != '0)
    else $error("dequeue served a level that is empty or out of credit");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> res_ready_i && cmd_valid_i)
    else $error("command taken without room for its result");

  a_grant_from_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.status == ST_GRANT |-> state_q == S_TAG)
    else $error("grant pushed outside the tag stage");

endmodule

`default_nettype wire

@@ rtl/mlqws_resq.sv @@
// Two-entry result queue between the back end and the result ports.
// Depends on mlqws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlqws_resq import mlqws_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_push_i,
  input  wire res_t res_i,
  output logic      res_ready_o,
  output logic      empty,
  input  wire logic pop,
  output res_t      res_o
);

  res_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign res_ready_o = (cnt_q != 2'd2);
  assign empty       = (cnt_q == 2'd0);
  assign res_o       = entry_q[rd_ptr_q];
  assign wr_en       = res_push_i && res_ready_o;
  assign rd_en       = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mlq_weighted_slot_scheduler.sv @@
// An enqueue result is pushed into the result queue from the execute state and a grant
// from the tag state that follows it; a dequeue that finds every level empty, or an
// enqueue to a level that does not exist, is answered from the idle state. A new command
// is taken only in the idle state and only while the result queue has room.
// Reset: asynchronous, active low; all levels read as empty and every credit as its full
// value at once, with no clearing pass. Tag memory contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module mlq_weighted_slot_scheduler import mlqws_pkg::*; #(
  parameter int NUM_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire logic            opcode_i,
  input  wire logic [TagW-1:0] task_tag_i,
  input  wire logic [LvlW-1:0] level_i,
  output logic                 empty,
  input  wire logic            pop,
  output logic [1:0]           status_o,
  output logic [TagW-1:0]      granted_tag_o,
  output logic [LvlW-1:0]      granted_level_o
);

  // The front queue holds up to two command beats, so the upstream side keeps moving
  // while the engine works through a dequeue.
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // The result queue holds up to two result beats; the engine starts a command only
  // when the queue has room, so a stalled consumer never loses a result.
  logic res_ready, res_push;
  res_t res_in, res_out;

  mlqws_front #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (op_e'(opcode_i)),
    .task_tag_i  (task_tag_i),
    .level_i     (level_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // The engine keeps one descriptor (head and count) per level, a credit per level and the
  // tag memory. Per-level flag vectors drive the lowest-level-first search; when no
  // non-empty level has credit, all credits are refilled in the same cycle as the search.
  mlqws_back #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (res_ready),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  mlqws_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_push_i  (res_push),
    .res_i       (res_in),
    .res_ready_o (res_ready),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_out)
  );

  assign status_o        = res_out.status;
  assign granted_tag_o   = res_out.tag;
  assign granted_level_o = res_out.level;

endmodule

`default_nettype wire
